// File: rtl/core/sha256mh_pkg.sv
// Package with shared types, constants and round functions of the SHA-256 message hasher.
`default_nettype none

package sha256mh_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL,
    ST_PAD,
    ST_LEN,
    ST_OUT
  } state_e;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LEN_START  = 6'd56;
  localparam logic [5:0] BLOCK_LAST = 6'd63;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [2:0] WORD_LAST  = 3'd7;

  localparam logic [31:0] K_TABLE [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  localparam logic [31:0] IV_TABLE [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                         input logic [31:0] g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/sha256_message_hasher_core.sv
// Message bytes enter one per cycle while the input is ready; a full block then runs
// 64 rounds and a final add. At message end, padding and length bytes enter one per
// cycle between blocks; eight digest items follow, one per cycle while the output is ready.
// One round unit is reused for all 64 rounds; the input is not ready while it runs.
// Reset is asynchronous and active low; it loads the initial hash values and clears counts.
`default_nettype none

module sha256_message_hasher_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic [0:0]  s_axis_tuser_i,   // [0] byte_present
  input  wire logic        s_axis_tlast_i,   // message_end
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,   // [31:0] digest_word
  output logic [2:0]       m_axis_tuser_o,   // [2:0] word_position
  output logic             m_axis_tlast_o    // last_word
);
  import sha256mh_pkg::*;

  state_e       state_q, state_d;
  logic [5:0]   fill_q, fill_d;
  logic [60:0]  msg_bytes_q, msg_bytes_d;
  logic [5:0]   round_q, round_d;
  logic         ending_q, ending_d;
  logic         pad_first_q, pad_first_d;
  logic         last_blk_q, last_blk_d;
  logic [2:0]   out_idx_q, out_idx_d;
  logic [31:0]  hash_q [8];
  logic [31:0]  wv_q [8];
  logic [511:0] win_q;

  logic         push;
  logic [7:0]   push_val;
  logic         load_wv;
  logic         do_round;
  logic         do_final;
  logic         out_step;
  logic [63:0]  bit_len;
  logic [7:0]   len_byte;
  logic [31:0]  w_cur;
  logic [31:0]  w_next;
  logic [31:0]  t1;
  logic [31:0]  t2;

  assign bit_len  = {msg_bytes_q, 3'b000};
  assign len_byte = bit_len[{~fill_q[2:0], 3'b000} +: 8];

  assign w_cur  = win_q[511:480];
  assign w_next = small_sigma1(win_q[63:32]) + win_q[223:192]
                + small_sigma0(win_q[479:448]) + w_cur;
  assign t1 = wv_q[7] + big_sigma1(wv_q[4]) + choose(wv_q[4], wv_q[5], wv_q[6])
            + K_TABLE[round_q] + w_cur;
  assign t2 = big_sigma0(wv_q[0]) + majority(wv_q[0], wv_q[1], wv_q[2]);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = (state_q == ST_OUT);
  assign m_axis_tdata_o  = hash_q[0];
  assign m_axis_tuser_o  = out_idx_q;
  assign m_axis_tlast_o  = (out_idx_q == WORD_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      msg_bytes_q <= '0;
      round_q     <= '0;
      ending_q    <= 1'b0;
      pad_first_q <= 1'b0;
      last_blk_q  <= 1'b0;
      out_idx_q   <= '0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      msg_bytes_q <= msg_bytes_d;
      round_q     <= round_d;
      ending_q    <= ending_d;
      pad_first_q <= pad_first_d;
      last_blk_q  <= last_blk_d;
      out_idx_q   <= out_idx_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    msg_bytes_d = msg_bytes_q;
    round_d     = round_q;
    ending_d    = ending_q;
    pad_first_d = pad_first_q;
    last_blk_d  = last_blk_q;
    out_idx_d   = out_idx_q;
    push        = 1'b0;
    push_val    = s_axis_tdata_i;
    load_wv     = 1'b0;
    do_round    = 1'b0;
    do_final    = 1'b0;
    out_step    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          if (s_axis_tuser_i[0]) begin
            push        = 1'b1;
            fill_d      = fill_q + 6'd1;
            msg_bytes_d = msg_bytes_q + 61'd1;
          end
          if (s_axis_tlast_i) begin
            ending_d    = 1'b1;
            pad_first_d = 1'b1;
          end
          if (s_axis_tuser_i[0] && (fill_q == BLOCK_LAST)) begin
            state_d = ST_ROUND;
            load_wv = 1'b1;
          end else if (s_axis_tlast_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        do_round = 1'b1;
        round_d  = round_q + 6'd1;
        if (round_q == ROUND_LAST) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        do_final = 1'b1;
        if (last_blk_q) begin
          state_d = ST_OUT;
        end else if (ending_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_PAD: begin
        push        = 1'b1;
        push_val    = pad_first_q ? PAD_BYTE : 8'h00;
        pad_first_d = 1'b0;
        fill_d      = fill_q + 6'd1;
        if (fill_q == BLOCK_LAST) begin
          state_d = ST_ROUND;
          load_wv = 1'b1;
        end else if (fill_q == LEN_START - 6'd1) begin
          state_d = ST_LEN;
        end
      end
      ST_LEN: begin
        push     = 1'b1;
        push_val = len_byte;
        fill_d   = fill_q + 6'd1;
        if (fill_q == BLOCK_LAST) begin
          state_d    = ST_ROUND;
          load_wv    = 1'b1;
          last_blk_d = 1'b1;
        end
      end
      ST_OUT: begin
        if (m_axis_tready_i) begin
          out_step  = 1'b1;
          out_idx_d = out_idx_q + 3'd1;
          if (out_idx_q == WORD_LAST) begin
            state_d     = ST_IDLE;
            msg_bytes_d = '0;
            fill_d      = '0;
            ending_d    = 1'b0;
            last_blk_d  = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // The digest leaves from word 0 while the initial values shift in from the top.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        hash_q[i] <= IV_TABLE[i];
      end
    end else if (do_final) begin
      for (int i = 0; i < 8; i++) begin
        hash_q[i] <= hash_q[i] + wv_q[i];
      end
    end else if (out_step) begin
      for (int i = 0; i < 7; i++) begin
        hash_q[i] <= hash_q[i + 1];
      end
      hash_q[7] <= IV_TABLE[out_idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_wv) begin
      for (int i = 0; i < 8; i++) begin
        wv_q[i] <= hash_q[i];
      end
    end else if (do_round) begin
      wv_q[0] <= t1 + t2;
      wv_q[1] <= wv_q[0];
      wv_q[2] <= wv_q[1];
      wv_q[3] <= wv_q[2];
      wv_q[4] <= wv_q[3] + t1;
      wv_q[5] <= wv_q[4];
      wv_q[6] <= wv_q[5];
      wv_q[7] <= wv_q[6];
    end
  end

  // Bytes and schedule words share one shift line; the current word sits at the top.
  always_ff @(posedge clk_i) begin
    if (push) begin
      win_q <= {win_q[503:0], push_val};
    end else if (do_round) begin
      win_q <= {win_q[479:0], w_next};
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/sha256mh_checker.sv
// Port checker for the SHA-256 message hasher core and its bind statement.
`default_nettype none

module sha256mh_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [31:0] m_axis_tdata_o,
  input wire logic [2:0]  m_axis_tuser_o,
  input wire logic        m_axis_tlast_o
);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(m_axis_tvalid_o && s_axis_tready_o))
    else $error("Input ready while a digest item is offered.");

  a_last_on_seven: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == (m_axis_tuser_o == 3'd7)))
    else $error("Last flag does not match the final word position.");

  a_word_sequence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o) |=>
      (m_axis_tvalid_o && (m_axis_tuser_o == $past(m_axis_tuser_o) + 3'd1)))
    else $error("Digest words are not offered in sequence.");

  a_ready_after_digest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o) |=> s_axis_tready_o)
    else $error("Input not ready after the last digest item.");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("Stalled digest item changed.");

endmodule

bind sha256_message_hasher_core sha256mh_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire

// File: tb/sha256_message_hasher_core_test.sv
// Self-checking testbench that streams messages into the SHA-256 hasher and checks every digest.
`timescale 1ns / 1ps

module sha256_message_hasher_core_test;

  localparam int          CYCLE_LIMIT = 200000;
  localparam int          HOLD_CYCLES = 400;
  localparam int          HOLD_AT     = 48;
  localparam int          DRAIN       = 300;
  localparam logic [7:0]  PAD_MARK    = 8'h80;
  localparam int          LEN_FIELD   = 56;

  typedef logic [255:0] digest_t;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       finish;
    logic       known;
    digest_t    digest;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  pos;
    logic        last;
  } digest_item_t;

  localparam digest_t EMPTY_DIGEST =
    256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
  localparam digest_t ABC_DIGEST =
    256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

  localparam logic [31:0] ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] START_CHAIN [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam int LONG_LENGTHS [6] = '{55, 56, 63, 64, 119, 120};

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = '0;   // [7:0] data_byte
  logic [0:0]  s_axis_tuser_i  = '0;   // [0] byte_present
  logic        s_axis_tlast_i  = 1'b0; // message_end
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;         // [31:0] digest_word
  logic [2:0]  m_axis_tuser_o;         // [2:0] word_position
  logic        m_axis_tlast_o;         // last_word

  logic [31:0]  chain [8];
  logic [7:0]   blk [64];
  logic [60:0]  nbytes;
  digest_item_t pending_words [$];
  int           mismatches  = 0;
  int           cycle_count = 0;
  bit           tx_calm     = 1'b0;
  bit           rx_calm     = 1'b0;

  msg_item_t plan [12] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
    '{8'h5a, 1'b0, 1'b0, 1'b0, '0},
    '{8'h61, 1'b1, 1'b0, 1'b0, '0},
    '{8'h62, 1'b1, 1'b0, 1'b0, '0},
    '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
    '{8'hff, 1'b1, 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b0, 1'b0, '0},
    '{8'h55, 1'b1, 1'b0, 1'b0, '0},
    '{8'haa, 1'b1, 1'b1, 1'b0, '0},
    '{8'h81, 1'b1, 1'b0, 1'b0, '0},
    '{8'h7e, 1'b0, 1'b1, 1'b0, '0},
    '{8'hff, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST}
  };

  sha256_message_hasher_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("sha256_message_hasher_core_test failed");
      $finish;
    end
  end

  function automatic logic [31:0] rot_right(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic int pick_gap(inout bit calm);
    if ($urandom_range(0, 15) == 0) calm = !calm;
    return calm ? 0 : int'($urandom_range(0, 5));
  endfunction

  function automatic msg_item_t make_item(input logic [7:0] data, input logic present,
                                          input logic finish);
    msg_item_t r;
    r = '0;
    r.data    = data;
    r.present = present;
    r.finish  = finish;
    return r;
  endfunction

  task automatic compress_chunk();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    for (int t = 0; t < 16; t++) w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      s0 = rot_right(w[t-15], 7) ^ rot_right(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = rot_right(w[t-2], 17) ^ rot_right(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int t = 0; t < 64; t++) begin
      s1 = rot_right(v[4], 6) ^ rot_right(v[4], 11) ^ rot_right(v[4], 25);
      t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[t] + w[t];
      s0 = rot_right(v[0], 2) ^ rot_right(v[0], 13) ^ rot_right(v[0], 22);
      t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int i = 7; i > 0; i--) v[i] = v[i-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
  endtask

  task automatic absorb_item(input msg_item_t r);
    int           fill;
    logic [63:0]  bitlen;
    digest_item_t d;
    if (r.present) begin
      fill = int'(nbytes[5:0]);
      blk[fill] = r.data;
      nbytes = nbytes + 61'd1;
      if (fill == 63) compress_chunk();
    end
    if (r.finish) begin
      fill = int'(nbytes[5:0]);
      blk[fill] = PAD_MARK;
      for (int i = fill + 1; i < 64; i++) blk[i] = '0;
      if (fill >= LEN_FIELD) begin
        compress_chunk();
        for (int i = 0; i < 64; i++) blk[i] = '0;
      end
      bitlen = {nbytes, 3'b000};
      for (int i = 0; i < 8; i++) blk[LEN_FIELD + i] = bitlen[63 - 8*i -: 8];
      compress_chunk();
      for (int i = 0; i < 8; i++) begin
        d.word = r.known ? r.digest[255 - 32*i -: 32] : chain[i];
        d.pos  = 3'(i);
        d.last = (i == 7);
        pending_words.push_back(d);
        chain[i] = START_CHAIN[i];
      end
      nbytes = '0;
    end
  endtask

  task automatic send_item(input msg_item_t r);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= r.data;
    s_axis_tuser_i  <= r.present;
    s_axis_tlast_i  <= r.finish;
    do @(posedge clk_i); while (!s_axis_tready_o);
    absorb_item(r);
  endtask

  initial begin : digest_sink
    int           gap;
    int           taken;
    digest_item_t want;
    taken = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (taken == HOLD_AT) begin
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        gap = pick_gap(rx_calm);
        if (gap > 0) begin
          m_axis_tready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      taken++;
      if (pending_words.size() == 0) begin
        $error("digest item with none expected: word %h, position %0d, last %b",
               m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        if (m_axis_tdata_o !== want.word) begin
          $error("digest_word: expected %h, got %h", want.word, m_axis_tdata_o);
          mismatches++;
        end
        if (m_axis_tuser_o !== want.pos) begin
          $error("word_position: expected %0d, got %0d", want.pos, m_axis_tuser_o);
          mismatches++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $error("last_word: expected %b, got %b", want.last, m_axis_tlast_o);
          mismatches++;
        end
      end
    end
  end

  initial begin : message_source
    int len;
    int sent;
    int msg_count;
    bit end_alone;
    for (int i = 0; i < 8; i++) chain[i] = START_CHAIN[i];
    for (int i = 0; i < 64; i++) blk[i] = '0;
    nbytes = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[r]) send_item(plan[r]);

    sent = 0;
    msg_count = 0;
    while (sent < 150) begin
      if (msg_count % 2 == 1 && sent < 40) len = LONG_LENGTHS[$urandom_range(0, 5)];
      else len = $urandom_range(0, 12);
      end_alone = $urandom_range(0, 1);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 9) == 0) send_item(make_item(8'($urandom_range(0, 255)), 1'b0, 1'b0));
        send_item(make_item(8'($urandom_range(0, 255)), 1'b1, (k == len - 1) && !end_alone));
        sent++;
      end
      if (len == 0 || end_alone) begin
        send_item(make_item(8'($urandom_range(0, 255)), 1'b0, 1'b1));
        sent++;
      end
      msg_count++;
    end
    s_axis_tvalid_i <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("sha256_message_hasher_core_test passed");
    end else begin
      $display("sha256_message_hasher_core_test failed");
    end
    $finish;
  end

endmodule
